[rtl/core/nrcw_pkg.sv]
`timescale 1ns / 1ps

package nrcw_pkg;

  // Event kinds carried on the input tuser field
  typedef enum logic [1:0] {
    FUNC_NEW_ACK = 2'd0,
    FUNC_DUP_ACK = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEG_SIZE          = 2'd0;
  localparam logic [1:0] CFG_INITIAL_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_INITIAL_THRESHOLD = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RST_SEG_SIZE          = 16'd1460;
  localparam logic [31:0] RST_INITIAL_WINDOW    = 32'd1460;
  localparam logic [31:0] RST_INITIAL_THRESHOLD = 32'd65535;

  localparam logic [15:0] TRIPLE_DUP   = 16'd3;
  localparam logic [15:0] PARTIAL_MAX  = 16'hFFFF;
  localparam logic [31:0] WINDOW_MAX   = 32'hFFFF_FFFF;

  // Stream widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 104;

  // Output tdata bit positions
  localparam int O_CWND_LO    = 0;
  localparam int O_SSTH_LO    = 32;
  localparam int O_RECOVERY   = 64;
  localparam int O_RETX       = 65;
  localparam int O_SENDP      = 66;
  localparam int O_RESTART    = 67;
  localparam int O_BACKOFF    = 68;
  localparam int O_RWV        = 69;
  localparam int O_RWS_LO     = 70;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_THR,
    ST_DIV,
    ST_UPD
  } state_t;

  // Per-state control strobes
  typedef struct packed {
    logic in_ready;
    logic prep_en;
    logic thr_en;
    logic div_en;
    logic commit;
  } ctl_t;

endpackage

[rtl/core/newreno_congestion_window_top.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// in_      | slave     | in_tvalid/tready   | tuser: func; tdata: ack_seq, dup_count,
//          |           |                    |   next_send_seq, peer_window
// out_     | master    | out_tvalid/tready  | tdata: window, threshold, flags, rewind_seq
// cfg_     | write     | cfg_we             | cfg_addr selects register, cfg_wdata
//
// Steps: an event passes through accept, prepare, threshold and update on its way to the
//   result register; a new ack in congestion avoidance also runs the 32-step restoring
//   divider (one 33-bit subtract per cycle), which forms seg_size*seg_size / cwnd.
// The input is ready only while the sequencer idles; one event is in flight at a time.
// A finished result sits in the output register while the next event is taken in;
//   the update step holds until that register is free.
// Reset (rst_n low, synchronous) loads the register defaults, the window, the threshold
//   and clears recovery state; no clearing pass is needed.

module newreno_congestion_window_top
  import nrcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input events
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] ack_seq, [47:32] dup_count, [79:48] next_send_seq, [111:80] peer_window
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]            in_tuser,
  // Results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] cwnd_out, [63:32] ssthresh_out, [64] in_recovery, [65] do_retransmit,
  // [66] send_pending, [67] restart_timer, [68] backoff_timer, [69] rewind_valid,
  // [101:70] rewind_seq, [103:102] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [31:0]           cfg_wdata
);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? WINDOW_MAX : s[31:0];
  endfunction

  // Configuration registers
  logic [15:0] seg_size_r;
  logic [31:0] init_win_r;
  logic [31:0] init_thr_r;

  // Connection state
  logic [31:0] cwnd_r, ssthresh_r, recover_r, high_ack_r;
  logic        fast_rec_r;
  logic [15:0] partial_r;

  // Captured event
  func_t       func_r;
  logic [31:0] ack_r, next_r, peer_r;
  logic [15:0] dup_r;

  // Values prepared ahead of the update
  logic [31:0] usable_r, delta_r, unacked_r, sq_r, rth_r;
  logic [17:0] seg3_r;
  logic        dge_r, ack_ge_rp_r, ack_gt_rp_r, cwnd_lt_ss_r, dup3_r;

  // Divider
  logic [31:0] rem_r, quo_r, dvsr_r;
  logic [4:0]  cnt_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  state_t state_r, state_nxt;
  ctl_t   ctl;
  logic   out_free;
  logic   need_div;

  assign out_free = !out_valid_r || out_tready;
  // Only a new ack outside recovery at or above the threshold runs the divider
  assign need_div = (func_r == FUNC_NEW_ACK) && !fast_rec_r && !cwnd_lt_ss_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_THR;
      ST_THR:  state_nxt = need_div ? ST_DIV : ST_UPD;
      ST_DIV:  if (cnt_r == 5'd0) state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State strobes
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_PREP: ctl.prep_en  = 1'b1;
      ST_THR:  ctl.thr_en   = 1'b1;
      ST_DIV:  ctl.div_en   = 1'b1;
      ST_UPD:  ctl.commit   = out_free;
      default: ctl = '0;
    endcase
  end

  assign in_tready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_size_r <= RST_SEG_SIZE;
      init_win_r <= RST_INITIAL_WINDOW;
      init_thr_r <= RST_INITIAL_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEG_SIZE:          seg_size_r <= cfg_wdata[15:0];
        CFG_INITIAL_WINDOW:    init_win_r <= cfg_wdata;
        CFG_INITIAL_THRESHOLD: init_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the event on transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && ctl.in_ready) begin
      func_r <= func_t'(in_tuser);
      ack_r  <= in_tdata[31:0];
      dup_r  <= in_tdata[47:32];
      next_r <= in_tdata[79:48];
      peer_r <= in_tdata[111:80];
    end
  end

  // Preparation: independent compares, differences and the square
  always_ff @(posedge clk) begin
    if (ctl.prep_en) begin
      usable_r     <= (cwnd_r < peer_r) ? cwnd_r : peer_r;
      delta_r      <= ack_r - high_ack_r;
      unacked_r    <= next_r - high_ack_r;
      sq_r         <= seg_size_r * seg_size_r;
      seg3_r       <= {2'b00, seg_size_r} + {1'b0, seg_size_r, 1'b0};
      ack_ge_rp_r  <= ack_r >= recover_r;
      ack_gt_rp_r  <= ack_r > recover_r;
      cwnd_lt_ss_r <= cwnd_r < ssthresh_r;
      dup3_r       <= dup_r == TRIPLE_DUP;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.thr_en) begin
      // Reduced threshold: half the usable window, no less than two segments
      rth_r <= ((usable_r >> 1) > {15'd0, seg_size_r, 1'b0}) ? (usable_r >> 1)
                                                             : {15'd0, seg_size_r, 1'b0};
      dge_r <= delta_r >= {16'd0, seg_size_r};
    end
  end

  // Restoring divider: one subtract per cycle, quotient shifts in from the right
  logic [32:0] div_shl;
  logic        div_ge;
  logic [32:0] div_sub;

  assign div_shl = {rem_r, quo_r[31]};
  assign div_ge  = div_shl >= {1'b0, dvsr_r};
  assign div_sub = div_shl - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (ctl.thr_en) begin
      rem_r  <= '0;
      quo_r  <= sq_r;
      dvsr_r <= (cwnd_r == '0) ? 32'd1 : cwnd_r;
      cnt_r  <= 5'd31;
    end else if (ctl.div_en) begin
      rem_r <= div_ge ? div_sub[31:0] : div_shl[31:0];
      quo_r <= {quo_r[30:0], div_ge};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  // Update: new state and the flags of this event
  logic [31:0] cwnd_nxt, ssthresh_nxt, recover_nxt, high_ack_nxt, rws_nxt;
  logic [15:0] partial_nxt;
  logic        fast_rec_nxt, retx_nxt, sendp_nxt, restart_nxt, backoff_nxt, rwv_nxt;
  logic [32:0] full_lim;
  logic [33:0] part_val;
  logic [31:0] ca_add;

  assign full_lim = {1'b0, unacked_r} + {17'd0, seg_size_r};
  assign part_val = {2'b00, cwnd_r} + {18'd0, (dge_r ? seg_size_r : 16'd0)}
                  - {2'b00, delta_r};
  assign ca_add   = (quo_r == '0) ? 32'd1 : quo_r;

  always_comb begin
    cwnd_nxt     = cwnd_r;
    ssthresh_nxt = ssthresh_r;
    recover_nxt  = recover_r;
    high_ack_nxt = high_ack_r;
    partial_nxt  = partial_r;
    fast_rec_nxt = fast_rec_r;
    retx_nxt     = 1'b0;
    sendp_nxt    = 1'b0;
    restart_nxt  = 1'b0;
    backoff_nxt  = 1'b0;
    rwv_nxt      = 1'b0;
    rws_nxt      = '0;
    unique case (func_r)
      FUNC_NEW_ACK: begin
        high_ack_nxt = ack_r;
        sendp_nxt    = 1'b1;
        restart_nxt  = 1'b1;
        if (fast_rec_r) begin
          if (ack_ge_rp_r) begin
            // Full ack: leave recovery and deflate the window
            cwnd_nxt     = (full_lim > {1'b0, ssthresh_r}) ? ssthresh_r : full_lim[31:0];
            fast_rec_nxt = 1'b0;
            partial_nxt  = '0;
          end else begin
            // Partial ack: deflate by acked bytes, retransmit the next hole
            if (part_val[33])      cwnd_nxt = '0;
            else if (part_val[32]) cwnd_nxt = WINDOW_MAX;
            else                   cwnd_nxt = part_val[31:0];
            restart_nxt = (partial_r == '0);
            if (partial_r != PARTIAL_MAX) partial_nxt = partial_r + 16'd1;
            retx_nxt = 1'b1;
          end
        end else if (cwnd_lt_ss_r) begin
          cwnd_nxt = sat_add(cwnd_r, {16'd0, seg_size_r});
        end else begin
          cwnd_nxt = sat_add(cwnd_r, ca_add);
        end
      end
      FUNC_DUP_ACK: begin
        if (fast_rec_r) begin
          // Inflate the window by one segment per duplicate
          cwnd_nxt  = sat_add(cwnd_r, {16'd0, seg_size_r});
          sendp_nxt = 1'b1;
        end else if (dup3_r && ack_gt_rp_r) begin
          fast_rec_nxt = 1'b1;
          partial_nxt  = '0;
          ssthresh_nxt = rth_r;
          cwnd_nxt     = sat_add(rth_r, {14'd0, seg3_r});
          recover_nxt  = next_r;
          retx_nxt     = 1'b1;
        end
      end
      FUNC_TIMEOUT: begin
        ssthresh_nxt = rth_r;
        cwnd_nxt     = init_win_r;
        fast_rec_nxt = 1'b0;
        partial_nxt  = '0;
        backoff_nxt  = 1'b1;
        retx_nxt     = 1'b1;
        rwv_nxt      = 1'b1;
        rws_nxt      = high_ack_r;
      end
      FUNC_UNUSED: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwnd_r     <= RST_INITIAL_WINDOW;
      ssthresh_r <= RST_INITIAL_THRESHOLD;
      fast_rec_r <= 1'b0;
      recover_r  <= '0;
      high_ack_r <= '0;
      partial_r  <= '0;
    end else if (ctl.commit) begin
      cwnd_r     <= cwnd_nxt;
      ssthresh_r <= ssthresh_nxt;
      fast_rec_r <= fast_rec_nxt;
      recover_r  <= recover_nxt;
      high_ack_r <= high_ack_nxt;
      partial_r  <= partial_nxt;
    end
  end

  // Output register: hold until the downstream takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data_r <= {2'b00, rws_nxt, rwv_nxt, backoff_nxt, restart_nxt, sendp_nxt,
                     retx_nxt, fast_rec_nxt, ssthresh_nxt, cwnd_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/core/nrcw_checker.sv]
`timescale 1ns / 1ps

module nrcw_checker
  import nrcw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // Result must hold while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // One event in flight: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // A timeout result rewinds, backs off, retransmits and leaves recovery
  a_timeout_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_RWV] |->
      out_tdata[O_BACKOFF] && out_tdata[O_RETX] && !out_tdata[O_RECOVERY])
    else $error("inconsistent timeout flags");

  // Timer restart comes only with a new ack, which always sends
  a_restart_sends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_RESTART] |-> out_tdata[O_SENDP] && !out_tdata[O_RWV])
    else $error("timer restart without send");

  // No result straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind newreno_congestion_window_top nrcw_checker u_nrcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
